/* rtl/clc_pkg.sv */
// Shared types and constants for the chunk LRU lookup cache.
// Used by every module of the block; depends on nothing.
package clc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ADDR_BITS   = 48;
    localparam int CHUNK_LOG2  = 18;

    // field widths of the stream payload
    localparam int ADDR_W = 48;
    localparam int OFS_W  = 18;
    localparam int SLOT_W = 4;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int ADDR_USED = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_W     = ADDR_USED - CHUNK_LOG2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_FIELD_W = SLOT_W + ADDR_W + OFS_W + ADDR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - OUT_FIELD_W;
    localparam int OUT_TUSER_W = 2;

    // tuser bit positions
    localparam int USER_HIT     = 0;
    localparam int USER_EVICTED = 1;

    localparam int QUEUE_DEPTH = 2;

    // one classified request between front and back
    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [CHUNK_LOG2-1:0] ofs;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/chunk_lru_cache_lookup_top.sv */
// Top level of the chunk LRU lookup cache: front end, request queue and
// lookup engine. Depends on clc_pkg, clc_front, clc_fifo and clc_back.
//
// Each input beat carries a device byte offset; each output beat reports the
// chunk base, the offset inside the chunk, hit, the buffer slot, and the base
// of an entry evicted for a miss. The block sustains one item per clock while
// the output is not stalled: the front end writes a classified request into a
// two-entry queue, and the lookup engine compares the tag against all slots in
// parallel and updates the per-slot recency ranks in the same cycle it loads
// the output register. A stalled output register holds the engine, and the
// queue absorbs two more beats before s_tready drops. The user must write
// capacity through cfg_wr_en/cfg_wr_data (reset 16, zero acts as 1, above
// ENTRIES acts as ENTRIES) only while idle; the block does not enforce it.
module chunk_lru_cache_lookup_top #(
    parameter int ENTRIES = clc_pkg::ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [clc_pkg::CAP_W-1:0]          cfg_wr_data,  // capacity
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [clc_pkg::IN_TDATA_W-1:0]     s_tdata,      // [47:0] byte_offset
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] slot, [51:4] chunk_base, [69:52] offset_in_chunk,
    // [117:70] evicted_base, [119:118] zero
    output logic [clc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [clc_pkg::OUT_TUSER_W-1:0]    m_tuser       // [0] hit, [1] evicted
);
    import clc_pkg::*;

    req_t      front_req, head_req;
    q_status_t q_status;
    logic      push, pop;

    clc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .req      (front_req)
    );

    clc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (front_req),
        .pop      (pop),
        .head_req (head_req),
        .status   (q_status)
    );

    clc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (head_req),
        .q_status    (q_status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* rtl/clc_front.sv */
// Front end: accepts input beats and splits the byte offset into chunk tag
// and offset within the chunk. Depends on clc_pkg.
module clc_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [clc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [47:0] byte_offset
    input  clc_pkg::q_status_t                q_status,
    output logic                              push,
    output clc_pkg::req_t                     req
);
    import clc_pkg::*;

    // bits above the used address width are dropped here
    assign req.tag  = s_tdata[ADDR_USED-1:CHUNK_LOG2];
    assign req.ofs  = s_tdata[CHUNK_LOG2-1:0];

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

endmodule

/* rtl/clc_fifo.sv */
// Short request queue between the front end and the lookup engine.
// Depends on clc_pkg.
module clc_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  clc_pkg::req_t      push_req,
    input  logic               pop,
    output clc_pkg::req_t      head_req,
    output clc_pkg::q_status_t status
);
    import clc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_req     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* rtl/clc_back.sv */
// Lookup engine: parallel tag compare, per-slot recency ranks, eviction and
// the output register. Depends on clc_pkg.
module clc_back #(
    parameter int ENTRIES = clc_pkg::ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [clc_pkg::CAP_W-1:0]          cfg_wr_data,
    input  clc_pkg::req_t                      req,
    input  clc_pkg::q_status_t                 q_status,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [clc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [clc_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import clc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [TAG_W-1:0]       tag_reg  [ENTRIES];
    logic [IDX_W-1:0]       rank_reg [ENTRIES];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]       cap_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [ENTRIES-1:0] valid_vec, match_vec, victim_vec;
    logic [IDX_W-1:0]   hit_slot, vic_slot, sel_slot, hit_rank, top_rank;
    logic [TAG_W-1:0]   vic_tag;
    logic [CMP_W-1:0]   cap_x, cap_eff, n_x;
    logic               hit, evict;
    logic [ADDR_W-1:0]  base, ev_base;

    always_comb begin
        cap_x = CMP_W'(cap_reg);
        if (cap_x == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_x > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_x;
        end
        n_x = CMP_W'(count_reg);

        hit_slot = '0;
        hit_rank = '0;
        vic_slot = '0;
        vic_tag  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            valid_vec[i]  = CNT_W'(i) < count_reg;
            match_vec[i]  = valid_vec[i] && (tag_reg[i] == req.tag);
            victim_vec[i] = valid_vec[i] && (rank_reg[i] == '0);
            if (match_vec[i]) begin
                hit_slot = hit_slot | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (victim_vec[i]) begin
                vic_slot = vic_slot | IDX_W'(i);
                vic_tag  = vic_tag | tag_reg[i];
            end
        end

        hit      = |match_vec;
        evict    = !hit && (count_reg != '0) && (n_x >= cap_eff);
        top_rank = IDX_W'(count_reg - 1'b1);
        sel_slot = hit ? hit_slot : (evict ? vic_slot : IDX_W'(count_reg));

        count_next = count_reg;
        if (pop && !hit && !evict) begin
            count_next = count_reg + 1'b1;
        end

        base    = ADDR_W'({req.tag, {CHUNK_LOG2{1'b0}}});
        ev_base = evict ? ADDR_W'({vic_tag, {CHUNK_LOG2{1'b0}}}) : '0;

        m_tdata_next = {{PAD_W{1'b0}}, ev_base, OFS_W'(req.ofs), base, SLOT_W'(sel_slot)};
        m_tuser_next = '0;
        m_tuser_next[USER_HIT]     = hit;
        m_tuser_next[USER_EVICTED] = evict;
    end

    // advance only when the output register is free or being drained
    assign pop      = !q_status.empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // recency ranks: 0 is least recent, count-1 most recent
    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit) begin
                    if (match_vec[i]) begin
                        rank_reg[i] <= top_rank;
                    end else if (valid_vec[i] && (rank_reg[i] > hit_rank)) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end else if (evict) begin
                    if (victim_vec[i]) begin
                        rank_reg[i] <= top_rank;
                        tag_reg[i]  <= req.tag;
                    end else if (valid_vec[i]) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end else if (CNT_W'(i) == count_reg) begin
                    rank_reg[i] <= IDX_W'(count_reg);
                    tag_reg[i]  <= req.tag;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above store depth");

    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_status.empty |-> $onehot0(match_vec))
        else $error("tag matches more than one valid slot");

    a_victim_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> $onehot(victim_vec))
        else $error("least recent slot not unique");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tuser_reg[USER_HIT] && m_tuser_reg[USER_EVICTED]))
        else $error("hit and eviction flagged together");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (hit || evict)) |=> $stable(count_reg))
        else $error("entry count changed on hit or eviction");
`endif

endmodule

/* tb/sv/chunk_lru_cache_lookup_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for chunk_lru_cache_lookup_top: streams byte offsets and
// checks every lookup result against an LRU predictor. Depends on clc_pkg.
module chunk_lru_cache_lookup_top_test;
    import clc_pkg::*;

    localparam int NSLOT       = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 44;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic [ADDR_W-1:0]     base;
        logic [OFS_W-1:0]      in_chunk;
        logic                  evicted;
        logic [ADDR_W-1:0]     ev_base;
    } lookup_res_t;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_MOSTLY} rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    chunk_lru_cache_lookup_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [TAG_W-1:0]  tag_mem [NSLOT];
    logic [SLOT_W-1:0] lru_list [NSLOT];   // least recent first
    int unsigned       n_valid = 0;
    logic [CAP_W-1:0]  cap_reg = CAP_RESET;

    logic [ADDR_W-1:0] offset_q [$];
    lookup_res_t       chunk_expect_q [$];

    int n_bad = 0;
    int n_results = 0;
    int n_hits = 0;
    int n_evicts = 0;
    int n_cfg = 0;

    function automatic void move_to_mru(input int unsigned pos);
        logic [SLOT_W-1:0] s;
        s = lru_list[pos];
        for (int unsigned k = pos; k + 1 < n_valid; k++)
            lru_list[k] = lru_list[k + 1];
        lru_list[n_valid - 1] = s;
    endfunction

    function automatic lookup_res_t lookup_chunk(input logic [ADDR_W-1:0] ofs);
        lookup_res_t r;
        logic [TAG_W-1:0] tag;
        int unsigned eff;
        int unsigned pos;
        tag = ofs[ADDR_W-1:CHUNK_LOG2];
        eff = (cap_reg == 0) ? 1 : ((cap_reg > NSLOT) ? NSLOT : cap_reg);
        r = '0;
        r.base = {tag, {CHUNK_LOG2{1'b0}}};
        r.in_chunk = ofs[CHUNK_LOG2-1:0];
        for (int unsigned p = 0; p < n_valid; p++) begin
            if (!r.hit && tag_mem[lru_list[p]] == tag) begin
                r.hit = 1'b1;
                r.slot = lru_list[p];
                pos = p;
            end
        end
        if (r.hit) begin
            move_to_mru(pos);
        end else if (n_valid >= eff && n_valid > 0) begin
            // reuse the least recent slot
            r.slot = lru_list[0];
            r.evicted = 1'b1;
            r.ev_base = {tag_mem[r.slot], {CHUNK_LOG2{1'b0}}};
            tag_mem[r.slot] = tag;
            move_to_mru(0);
        end else begin
            r.slot = SLOT_W'(n_valid);
            tag_mem[r.slot] = tag;
            lru_list[n_valid] = r.slot;
            n_valid++;
        end
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready)
                chunk_expect_q.push_back(lookup_chunk(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (offset_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= offset_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes at random intervals, plus one long hold
    rx_mode_t rx_mode = RX_STREAM;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       rx_cyc = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cyc++;
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && m_tvalid && rx_cyc >= 400) begin
                // back up the queue until the input stalls
                hold_done = 1'b1;
                hold_left = 150;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STREAM: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        lookup_res_t got;
        lookup_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser[USER_HIT];
            got.evicted = m_tuser[USER_EVICTED];
            got.slot = m_tdata[SLOT_W-1:0];
            got.base = m_tdata[SLOT_W +: ADDR_W];
            got.in_chunk = m_tdata[SLOT_W + ADDR_W +: OFS_W];
            got.ev_base = m_tdata[SLOT_W + ADDR_W + OFS_W +: ADDR_W];
            n_results++;
            if (chunk_expect_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected result beat slot=%0d base=%h", $realtime,
                             got.slot, got.base);
            end else begin
                want = chunk_expect_q.pop_front();
                if (want.hit) n_hits++;
                if (want.evicted) n_evicts++;
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("%0t: mismatch on result %0d", $realtime, n_results);
                        $display("  exp hit=%b slot=%0d base=%h ofs=%h ev=%b ev_base=%h",
                                 want.hit, want.slot, want.base, want.in_chunk,
                                 want.evicted, want.ev_base);
                        $display("  got hit=%b slot=%0d base=%h ofs=%h ev=%b ev_base=%h",
                                 got.hit, got.slot, got.base, got.in_chunk,
                                 got.evicted, got.ev_base);
                    end
                end
            end
        end
    end

    int cyc = 0;
    always @(posedge aclk) begin
        cyc++;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc,
                     chunk_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (!(offset_q.size() == 0 && !s_tvalid && chunk_expect_q.size() == 0));
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        cap_reg = value;
        n_cfg++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    int cap_plan [9] = '{0, 1, 5, 31, 17, 3, 16, 8, 2};

    initial begin
        logic [TAG_W-1:0] tag_pool [$];
        logic [ADDR_W-1:0] ofs;
        int eff;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of the offset, a hit inside the same chunk
        @(negedge aclk);
        offset_q.push_back('0);
        offset_q.push_back({ADDR_W{1'b1}});
        offset_q.push_back(ADDR_W'(18'h3FFFF));
        offset_q.push_back(ADDR_W'(1) << CHUNK_LOG2);
        offset_q.push_back((ADDR_W'(1) << CHUNK_LOG2) | ADDR_W'(18'h2AAAA));
        offset_q.push_back({{TAG_W{1'b1}}, {CHUNK_LOG2{1'b0}}});
        offset_q.push_back({{TAG_W{1'b0}}, 18'h15555});
        wait_idle();

        // capacity zero first evicts below the current count, later ones refill
        foreach (cap_plan[ph]) begin
            write_capacity(CAP_W'(cap_plan[ph]));
            eff = (cap_plan[ph] == 0) ? 1 : ((cap_plan[ph] > NSLOT) ? NSLOT : cap_plan[ph]);
            tag_pool.delete();
            for (int k = 0; k < eff + int'($urandom_range(0, 3)); k++) begin
                if (k == 0)
                    tag_pool.push_back((ph % 2 == 1) ? {TAG_W{1'b1}} : '0);
                else
                    tag_pool.push_back(TAG_W'($urandom));
            end
            @(negedge aclk);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 15)
                    ofs = ADDR_W'({$urandom, $urandom});
                else
                    ofs = {tag_pool[$urandom_range(0, tag_pool.size() - 1)],
                           CHUNK_LOG2'($urandom)};
                offset_q.push_back(ofs);
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        $display("covered %0d lookups over %0d capacity writes: %0d hits, %0d evictions",
                 n_results, n_cfg, n_hits, n_evicts);
        $display("long output stall applied: %0d, failures: %0d", hold_done, n_bad);
        if (n_bad == 0 && chunk_expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
